[rtl/complementary_tilt_filter_macros.svh]
// assertion helpers for the tilt filter, clocked on clk, quiet in reset
`ifndef COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define COMPLEMENTARY_TILT_FILTER_MACROS_SVH

// property must hold at every edge outside reset
`define CTF_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CTF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/ctf_pkg.sv]
package ctf_pkg;

	localparam int STATE_WIDTH_DEF = 24;
	localparam int CORDIC_ITER_DEF = 16;
	localparam int ANG_FRAC = 21;
	localparam int ATAN_LEN = 24;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_WEIGHT = 8'd1;
	localparam logic [15:0] GAIN_RST = 16'd1311;
	localparam logic [15:0] WEIGHT_RST = 16'd655;

	typedef struct packed {
		logic signed [15:0] gyro_rate_x;
		logic signed [15:0] gyro_rate_y;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
	} out_item_t;

	// classified sample as queued for the back end
	typedef struct packed {
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic [15:0] mag_x;
		logic [15:0] mag_y;
		logic [15:0] mag_z;
		logic pos_x;
		logic pos_y;
	} work_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// atan(2^-i) in q.21
	function automatic logic signed [24:0] atan_lut(input logic [4:0] i);
		logic signed [24:0] v;
		case (i)
			5'd0: v = 25'sd1647099;
			5'd1: v = 25'sd972340;
			5'd2: v = 25'sd513757;
			5'd3: v = 25'sd260791;
			5'd4: v = 25'sd130902;
			5'd5: v = 25'sd65515;
			5'd6: v = 25'sd32765;
			5'd7: v = 25'sd16384;
			5'd8: v = 25'sd8192;
			5'd9: v = 25'sd4096;
			5'd10: v = 25'sd2048;
			5'd11: v = 25'sd1024;
			5'd12: v = 25'sd512;
			5'd13: v = 25'sd256;
			5'd14: v = 25'sd128;
			5'd15: v = 25'sd64;
			5'd16: v = 25'sd32;
			5'd17: v = 25'sd16;
			5'd18: v = 25'sd8;
			5'd19: v = 25'sd4;
			5'd20: v = 25'sd2;
			5'd21: v = 25'sd1;
			default: v = 25'sd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/ctf_front.sv]
module ctf_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  ctf_pkg::in_item_t  in_data,
	input  ctf_pkg::q_status_t q_status,
	output logic               q_push,
	output ctf_pkg::work_item_t q_item
);

	function automatic logic [15:0] mag16(input logic signed [15:0] a);
		return a[15] ? 16'(-a) : 16'(a);
	endfunction

	assign in_ready = !q_status.full;
	assign q_push = in_valid && in_ready;

	always_comb begin
		q_item.rate_x = in_data.gyro_rate_x;
		q_item.rate_y = in_data.gyro_rate_y;
		q_item.mag_x = mag16(in_data.accel_x);
		q_item.mag_y = mag16(in_data.accel_y);
		q_item.mag_z = mag16(in_data.accel_z);
		// root keeps its sign only for a strictly positive axis
		q_item.pos_x = !in_data.accel_x[15] && (in_data.accel_x != 16'sd0);
		q_item.pos_y = !in_data.accel_y[15] && (in_data.accel_y != 16'sd0);
	end

endmodule

[rtl/ctf_queue.sv]
`include "complementary_tilt_filter_macros.svh"

module ctf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ctf_pkg::work_item_t push_item,
	input  logic                pop,
	output ctf_pkg::work_item_t pop_item,
	output ctf_pkg::q_status_t  status
);

	ctf_pkg::work_item_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign status.full = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`CTF_NEVER(a_q_overflow, push && status.full, "queue written while full")
	`CTF_NEVER(a_q_underflow, pop && status.empty, "queue read while empty")
	`CTF_CHECK(a_q_count, count_q != 2'd3, "queue count out of range")

endmodule

[rtl/ctf_back.sv]
`include "complementary_tilt_filter_macros.svh"

module ctf_back #(
	parameter int STATE_WIDTH = ctf_pkg::STATE_WIDTH_DEF,
	parameter int CORDIC_ITERATIONS = ctf_pkg::CORDIC_ITER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ctf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          q_valid,
	input  ctf_pkg::work_item_t           q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ctf_pkg::out_item_t            out_data
);

	localparam int SW = STATE_WIDTH;
	localparam int FRAC = SW - 3;
	localparam int CW = 28;
	localparam int MW = SW + 19;
	localparam int NI = (CORDIC_ITERATIONS < ctf_pkg::ATAN_LEN) ?
		CORDIC_ITERATIONS : ctf_pkg::ATAN_LEN;
	localparam logic [4:0] IT_LAST = 5'(NI - 1);

	// angle q.21 to state format
	localparam int A_UP = (FRAC >= ctf_pkg::ANG_FRAC) ? FRAC - ctf_pkg::ANG_FRAC : 0;
	localparam int A_DN = (FRAC < ctf_pkg::ANG_FRAC) ? ctf_pkg::ANG_FRAC - FRAC : 0;
	localparam logic signed [63:0] A_RND = (A_DN > 0) ? (64'sd1 <<< (A_DN - 1)) : 64'sd0;
	// gyro step q6.28 to state format
	localparam int G_UP = (FRAC >= 28) ? FRAC - 28 : 0;
	localparam int G_DN = (FRAC < 28) ? 28 - FRAC : 0;
	localparam logic signed [63:0] G_RND = (G_DN > 0) ? (64'sd1 <<< (G_DN - 1)) : 64'sd0;
	// state to q3.13 output
	localparam int O_DN = FRAC - 13;
	localparam logic signed [63:0] O_RND = (O_DN > 0) ? (64'sd1 <<< (O_DN - 1)) : 64'sd0;

	localparam logic signed [63:0] SMAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
	localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
	localparam logic signed [63:0] OMAX = 64'sd32767;
	localparam logic signed [63:0] OMIN = -64'sd32768;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQRT = 4'd1;
	localparam logic [3:0] S_CORDIC = 4'd2;
	localparam logic [3:0] S_GYRO = 4'd3;
	localparam logic [3:0] S_STEP = 4'd4;
	localparam logic [3:0] S_MIX1 = 4'd5;
	localparam logic [3:0] S_MIX2 = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;
	localparam logic [3:0] S_OUT = 4'd8;

	logic [3:0] state_q;
	logic axis_q;
	ctf_pkg::work_item_t item_q;
	logic [15:0] gain_q;
	logic [15:0] weight_q;
	logic signed [SW-1:0] tilt_x_q;
	logic signed [SW-1:0] tilt_y_q;
	logic [23:0] n_q;
	logic [23:0] r_q;
	logic [23:0] bit_q;
	logic signed [CW-1:0] cx_q;
	logic signed [CW-1:0] cy_q;
	logic signed [24:0] cz_q;
	logic [4:0] it_q;
	logic signed [33:0] prod_q;
	logic signed [SW-1:0] ang_q;
	logic signed [SW-1:0] sum_q;
	logic signed [MW-1:0] mix_q;
	logic out_valid_q;
	ctf_pkg::out_item_t out_q;

	logic [23:0] r_plus;
	logic sq_take;
	logic [23:0] n_next;
	logic [23:0] r_next;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] root_sh;
	logic root_pos;
	logic signed [15:0] rate_sel;
	logic signed [SW-1:0] tilt_sel;
	logic signed [63:0] ang_w;
	logic signed [63:0] step_w;
	logic signed [63:0] sum_w;
	logic signed [63:0] fin_w;
	logic signed [SW-1:0] fin_sat;
	logic signed [63:0] ox_w;
	logic signed [63:0] oy_w;
	logic out_free;
	logic out_load;

	function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
		input logic signed [63:0] hi, input logic signed [63:0] lo);
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	always_comb begin
		r_plus = r_q + bit_q;
		sq_take = (n_q >= r_plus);
		n_next = sq_take ? (n_q - r_plus) : n_q;
		r_next = sq_take ? ((r_q >> 1) + bit_q) : (r_q >> 1);
		root_pos = axis_q ? item_q.pos_x : item_q.pos_y;
		root_sh = CW'({r_next, 8'h00});
		xs = cx_q >>> it_q;
		ys = cy_q >>> it_q;
		rate_sel = axis_q ? item_q.rate_y : item_q.rate_x;
		tilt_sel = axis_q ? tilt_y_q : tilt_x_q;
		ang_w = ((64'(cz_q) + A_RND) >>> A_DN) <<< A_UP;
		step_w = ((64'(prod_q) + G_RND) >>> G_DN) <<< G_UP;
		sum_w = sat_to(64'(tilt_sel) + step_w, SMAX, SMIN);
		fin_w = sat_to(64'((mix_q + MW'(32768)) >>> 16), SMAX, SMIN);
		fin_sat = fin_w[SW-1:0];
		ox_w = sat_to((64'(tilt_x_q) + O_RND) >>> O_DN, OMAX, OMIN);
		oy_w = sat_to((64'(tilt_y_q) + O_RND) >>> O_DN, OMAX, OMIN);
		out_free = !out_valid_q || out_ready;
		out_load = (state_q == S_OUT) && out_free;
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= q_item;
				n_q <= {q_item.mag_y, 8'h00};
				r_q <= 24'd0;
				bit_q <= 24'h400000;
			end
			S_SQRT: begin
				n_q <= n_next;
				r_q <= r_next;
				bit_q <= bit_q >> 2;
				cx_q <= CW'({item_q.mag_z, 8'h00});
				cy_q <= root_pos ? root_sh : -root_sh;
				cz_q <= 25'sd0;
				it_q <= 5'd0;
			end
			S_CORDIC: begin
				it_q <= it_q + 5'd1;
				if (!cy_q[CW-1] && (cy_q != '0)) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + ctf_pkg::atan_lut(it_q);
				end else if (cy_q[CW-1]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - ctf_pkg::atan_lut(it_q);
				end
			end
			S_GYRO: begin
				prod_q <= 34'(rate_sel * $signed({1'b0, gain_q}));
				ang_q <= ang_w[SW-1:0];
			end
			S_STEP: begin
				sum_q <= sum_w[SW-1:0];
			end
			S_MIX1: begin
				mix_q <= MW'(sum_q * $signed({1'b0, 17'h10000 - {1'b0, weight_q}}));
			end
			S_MIX2: begin
				mix_q <= mix_q + MW'(ang_q * $signed({1'b0, weight_q}));
			end
			S_FIN: begin
				n_q <= {item_q.mag_x, 8'h00};
				r_q <= 24'd0;
				bit_q <= 24'h400000;
			end
			S_OUT: begin
				if (out_free) begin
					out_q.angle_x <= ox_w[15:0];
					out_q.angle_y <= oy_w[15:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= 1'b0;
			gain_q <= ctf_pkg::GAIN_RST;
			weight_q <= ctf_pkg::WEIGHT_RST;
			tilt_x_q <= '0;
			tilt_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == ctf_pkg::CFG_GYRO_GAIN)) begin
				gain_q <= cfg_data;
			end
			if (cfg_we && (cfg_index == ctf_pkg::CFG_ACCEL_WEIGHT)) begin
				weight_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					axis_q <= 1'b0;
					if (q_valid) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (bit_q[0]) begin
						state_q <= S_CORDIC;
					end
				end
				S_CORDIC: begin
					if (it_q == IT_LAST) begin
						state_q <= S_GYRO;
					end
				end
				S_GYRO: state_q <= S_STEP;
				S_STEP: state_q <= S_MIX1;
				S_MIX1: state_q <= S_MIX2;
				S_MIX2: state_q <= S_FIN;
				S_FIN: begin
					if (axis_q) begin
						tilt_y_q <= fin_sat;
						state_q <= S_OUT;
					end else begin
						tilt_x_q <= fin_sat;
						axis_q <= 1'b1;
						state_q <= S_SQRT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CTF_CHECK(a_out_no_clobber, out_valid_q && !out_ready && state_q == S_OUT |=> $stable(out_q),
		"pending result overwritten")
	`CTF_CHECK(a_pop_only_idle, q_pop |=> state_q == S_SQRT && !axis_q,
		"item taken outside idle")

endmodule

[rtl/complementary_tilt_filter.sv]
// one result per sample; each item runs through the shared sequencer: 12 square-root steps,
// the cordic steps and 5 multiply/blend steps per axis, plus pop and output load
// a two-entry queue takes up to two further samples while one is being worked on
// async active-low reset clears both tilt angles, the queue and the output valid flag, and
// loads the default gyro gain and blend weight
module complementary_tilt_filter #(
	parameter int STATE_WIDTH = ctf_pkg::STATE_WIDTH_DEF,
	parameter int CORDIC_ITERATIONS = ctf_pkg::CORDIC_ITER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ctf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ctf_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ctf_pkg::out_item_t            out_data
);

	ctf_pkg::q_status_t q_status;
	ctf_pkg::work_item_t push_item;
	ctf_pkg::work_item_t pop_item;
	logic push;
	logic pop;

	ctf_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_status (q_status),
		.q_push   (push),
		.q_item   (push_item)
	);

	ctf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	ctf_back #(
		.STATE_WIDTH       (STATE_WIDTH),
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (!q_status.empty),
		.q_item    (pop_item),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[sim/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = ctf_pkg::STATE_WIDTH_DEF;
	localparam int FRAC = SW - 3;
	localparam int ITERS = ctf_pkg::CORDIC_ITER_DEF;
	localparam longint CYCLE_LIMIT = 800000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ctf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	ctf_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	ctf_pkg::out_item_t out_data;

	complementary_tilt_filter dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// predictor state
	longint gain_q;
	longint weight_q;
	longint tilt_x_q;
	longint tilt_y_q;
	ctf_pkg::out_item_t angle_queue[$];
	int mismatches;
	longint cycles;
	bit quiet_in;
	bit quiet_out;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_to(longint v, int from, int to);
		if (to >= from)
			return v <<< (to - from);
		return asr(v + (64'sd1 <<< (from - to - 1)), from - to);
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint root_signed(longint a);
		longint mag;
		longint n;
		longint r;
		longint b;
		mag = (a < 0) ? -a : a;
		n = mag << 8;
		r = 0;
		b = 64'sd1 << 30;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return (a > 0) ? r : -r;
	endfunction

	function automatic longint vector_angle(longint yin, longint xin);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		x = xin * 256;
		y = yin * 256;
		z = 0;
		for (int i = 0; i < ITERS; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(ctf_pkg::atan_lut(i[4:0]));
			end else if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(ctf_pkg::atan_lut(i[4:0]));
			end
		end
		return z;
	endfunction

	function automatic longint blend_axis(longint tilt, longint rate, longint root, longint zmag);
		longint step;
		longint acc;
		longint mix;
		step = round_to(rate * gain_q, 28, FRAC);
		acc = round_to(vector_angle(root, zmag), ctf_pkg::ANG_FRAC, FRAC);
		tilt = clamp(tilt + step, SW);
		mix = (65536 - weight_q) * tilt + weight_q * acc;
		return clamp(asr(mix + 32768, 16), SW);
	endfunction

	function automatic void predict_angles(ctf_pkg::in_item_t s);
		longint zmag;
		ctf_pkg::out_item_t r;
		zmag = (s.accel_z < 0) ? -longint'(s.accel_z) : longint'(s.accel_z);
		tilt_x_q = blend_axis(tilt_x_q, s.gyro_rate_x, root_signed(s.accel_y), zmag);
		tilt_y_q = blend_axis(tilt_y_q, s.gyro_rate_y, root_signed(s.accel_x), zmag);
		r.angle_x = 16'(clamp(round_to(tilt_x_q, FRAC, 13), 16));
		r.angle_y = 16'(clamp(round_to(tilt_y_q, FRAC, 13), 16));
		angle_queue.push_back(r);
	endfunction

	// output side: random stall unless quiet_out is set, check every transfer
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (angle_queue.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result %h", out_data);
				end else begin
					if (out_data.angle_x !== angle_queue[0].angle_x ||
					    out_data.angle_y !== angle_queue[0].angle_y) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch exp x=%0d y=%0d got x=%0d y=%0d",
								angle_queue[0].angle_x, angle_queue[0].angle_y,
								out_data.angle_x, out_data.angle_y);
					end
					void'(angle_queue.pop_front());
				end
			end
			out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 21);
		end
	end

	// valid stays up between back-to-back samples and drops only while idling
	task automatic send_sample(ctf_pkg::in_item_t s);
		while (!quiet_in && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_angles(s);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (angle_queue.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [ctf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ctf_pkg::CFG_GYRO_GAIN)
			gain_q = val;
		else if (idx == ctf_pkg::CFG_ACCEL_WEIGHT)
			weight_q = val;
		@(posedge clk);
	endtask

	function automatic ctf_pkg::in_item_t make_sample(int gx, int gy, int ax, int ay, int az);
		ctf_pkg::in_item_t s;
		s.gyro_rate_x = 16'(gx);
		s.gyro_rate_y = 16'(gy);
		s.accel_x = 16'(ax);
		s.accel_y = 16'(ay);
		s.accel_z = 16'(az);
		return s;
	endfunction

	function automatic ctf_pkg::in_item_t random_sample(bit tame);
		ctf_pkg::in_item_t s;
		s = ctf_pkg::in_item_t'({$urandom, $urandom, $urandom});
		// mostly gentle gyro rates and a z axis near gravity (x and y stay full-range), otherwise full-range noise
		if (tame) begin
			s.gyro_rate_x = 16'($signed($urandom_range(4000)) - 2000);
			s.gyro_rate_y = 16'($signed($urandom_range(4000)) - 2000);
			s.accel_z = 16'($signed($urandom_range(1000)) + 2000);
		end
		return s;
	endfunction

	task automatic test_directed();
		send_sample(make_sample(0, 0, 0, 0, 0));
		send_sample(make_sample(0, 0, 0, 0, 2511));
		send_sample(make_sample(0, 0, 0, 0, -2511));
		send_sample(make_sample(0, 0, 100, -100, 0));
		send_sample(make_sample(0, 0, -32768, 32767, 0));
		send_sample(make_sample(32767, 32767, 32767, 32767, 32767));
		send_sample(make_sample(-32768, -32768, -32768, -32768, -32768));
		send_sample(make_sample(1, -1, 1, -1, 1));
		send_sample(make_sample(0, 0, 0, 32767, -32768));
		send_sample(make_sample(-32768, 32767, 0, 0, 256));
	endtask

	task automatic test_registers();
		drain_results();
		write_reg(ctf_pkg::CFG_GYRO_GAIN, 16'hFFFF);
		write_reg(ctf_pkg::CFG_ACCEL_WEIGHT, 16'h0000);
		write_reg(8'hFF, 16'h1234);
		repeat (12) send_sample(make_sample(32767, -32768, 0, 0, 256));
		drain_results();
		write_reg(ctf_pkg::CFG_GYRO_GAIN, 16'h0000);
		write_reg(ctf_pkg::CFG_ACCEL_WEIGHT, 16'hFFFF);
		repeat (4) send_sample(make_sample(5, -5, 32767, -32768, 0));
		drain_results();
	endtask

	task automatic test_random(int n, bit calm);
		quiet_in = calm;
		quiet_out = calm;
		for (int i = 0; i < n; i++)
			send_sample(random_sample($urandom_range(99) < 75));
		quiet_in = 0;
		quiet_out = 0;
	endtask

	task automatic test_settings();
		drain_results();
		write_reg(ctf_pkg::CFG_GYRO_GAIN, 16'($urandom));
		write_reg(ctf_pkg::CFG_ACCEL_WEIGHT, 16'($urandom));
		test_random(300, 0);
		drain_results();
		write_reg(ctf_pkg::CFG_GYRO_GAIN, ctf_pkg::GAIN_RST);
		write_reg(ctf_pkg::CFG_ACCEL_WEIGHT, ctf_pkg::WEIGHT_RST);
		test_random(300, 0);
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cycles = 0;
		mismatches = 0;
		quiet_in = 0;
		quiet_out = 0;
		gain_q = ctf_pkg::GAIN_RST;
		weight_q = ctf_pkg::WEIGHT_RST;
		tilt_x_q = 0;
		tilt_y_q = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 0);
		test_random(100, 1);
		test_registers();
		test_settings();
		drain_results();
		if (mismatches == 0 && angle_queue.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule

[complementary_tilt_filter.f]
+incdir+rtl
rtl/ctf_pkg.sv
rtl/ctf_front.sv
rtl/ctf_queue.sv
rtl/ctf_back.sv
rtl/complementary_tilt_filter.sv
sim/tb_top.sv
